FILE: rtl/core/crte_pkg.sv
package crte_pkg;

    localparam int NUM_RULES   = 16;
    localparam int IDX_W       = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
    localparam int CNT_W       = $clog2(NUM_RULES + 1);
    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] CMD_EVENT  = 3'd0;
    localparam logic [2:0] CMD_TICK   = 3'd1;
    localparam logic [2:0] CMD_ADD    = 3'd2;
    localparam logic [2:0] CMD_REMOVE = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_CONFLICT  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_BAD_INDEX = 3'd5;

    localparam logic [2:0] CMP_GT = 3'd0;
    localparam logic [2:0] CMP_GE = 3'd1;
    localparam logic [2:0] CMP_EQ = 3'd2;
    localparam logic [2:0] CMP_NE = 3'd3;
    localparam logic [2:0] CMP_LE = 3'd4;
    localparam logic [2:0] CMP_LT = 3'd5;

    localparam logic [2:0] MODE_FOLLOW    = 3'd0;
    localparam logic [2:0] MODE_PULSE     = 3'd1;
    localparam logic [2:0] MODE_ON_DELAY  = 3'd2;
    localparam logic [2:0] MODE_OFF_DELAY = 3'd3;
    localparam logic [2:0] MODE_TOGGLE    = 3'd4;
    localparam logic [2:0] MODE_FORCE_ON  = 3'd5;
    localparam logic [2:0] MODE_FORCE_OFF = 3'd6;

    localparam logic [7:0] CFG_INPUT_LIMIT  = 8'd0;
    localparam logic [7:0] CFG_OUTPUT_LIMIT = 8'd1;

    localparam logic KIND_OUTPUT = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // queued request; value carries the event value or the new threshold
    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] src;
        logic [31:0] value;
        logic [31:0] ids;
        logic [23:0] ctl;
        logic        add_ok;
        logic [5:0]  rm_idx;
    } req_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] target;
        logic        level;
        logic        tog;
        logic [5:0]  pos;
        logic [2:0]  status;
    } res_t;

    function automatic logic cmp_hit(input logic [2:0] op, input logic signed [31:0] a,
                                     input logic signed [31:0] b);
        logic r;
        case (op)
            CMP_GT:  r = a > b;
            CMP_GE:  r = a >= b;
            CMP_EQ:  r = a == b;
            CMP_NE:  r = a != b;
            CMP_LE:  r = a <= b;
            CMP_LT:  r = a < b;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_force(input logic [2:0] m);
        return (m == MODE_FORCE_ON) || (m == MODE_FORCE_OFF);
    endfunction

endpackage

FILE: rtl/core/crte_front.sv
module crte_front
    import crte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [15:0] event_source,
    input  logic [31:0] event_value,
    input  logic [15:0] new_input_id,
    input  logic [15:0] new_output_id,
    input  logic [31:0] new_threshold,
    input  logic [2:0]  new_compare_op,
    input  logic [2:0]  new_mode,
    input  logic [15:0] new_duration,
    input  logic        new_level_true,
    input  logic        new_level_false,
    input  logic [5:0]  remove_index,
    output logic        q_valid,
    output req_t        q_req,
    input  logic        q_pop
);

    logic [15:0] in_lim_reg;
    logic [15:0] out_lim_reg;
    req_t        fifo_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  fill_reg;
    req_t        req;
    logic        timed;
    logic        known;
    logic        push;

    always_comb
    begin
        timed = (new_mode == MODE_PULSE) || (new_mode == MODE_ON_DELAY) ||
                (new_mode == MODE_OFF_DELAY);
        known = (command == CMD_EVENT) || (command == CMD_TICK) || (command == CMD_ADD) ||
                (command == CMD_REMOVE) || (command == CMD_CLEAR);
        req.cmd    = command;
        req.src    = event_source;
        req.value  = (command == CMD_ADD) ? new_threshold : event_value;
        req.ids    = {new_output_id, new_input_id};
        req.ctl    = {new_level_false, new_level_true, new_duration, new_mode, new_compare_op};
        req.add_ok = (new_input_id < in_lim_reg) && (new_output_id < out_lim_reg) &&
                     (new_compare_op <= CMP_LT) && (new_mode <= MODE_FORCE_OFF) &&
                     !(timed && (new_duration == 16'd0));
        req.rm_idx = remove_index;
    end

    assign in_stall = (fill_reg == 2'd2);
    // unknown commands are taken and dropped
    assign push     = in_valid && !in_stall && known;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_req    = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_lim_reg  <= 16'hFFFF;
            out_lim_reg <= 16'hFFFF;
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            fill_reg    <= 2'd0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_INPUT_LIMIT))
                in_lim_reg <= cfg_data;
            if (cfg_we && (cfg_index == CFG_OUTPUT_LIMIT))
                out_lim_reg <= cfg_data;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= req;
    end

endmodule

FILE: rtl/core/crte_back.sv
module crte_back
    import crte_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  req_t q_req,
    output logic q_pop,
    output logic out_valid,
    input  logic out_stall,
    output res_t out_res,
    output logic out_last
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]       state_reg, state_next;
    req_t             req_reg;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      time_reg, time_next;
    logic [RES_W-1:0] nres_reg, nres_next;
    logic             pend_valid_reg, pend_valid_next;
    res_t             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    res_t             out_reg, out_next;
    logic             out_last_reg, out_last_next;

    logic [31:0] ids_mem [NUM_RULES];
    logic [31:0] thr_mem [NUM_RULES];
    logic [23:0] ctl_mem [NUM_RULES];
    logic [2:0]  flg_mem [NUM_RULES];
    logic [31:0] dl_mem  [NUM_RULES];

    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] pos_inc;
    logic [IDX_W-1:0] idx_inc;
    logic [31:0]      r_ids, r_thr, r_dl;
    logic [23:0]      r_ctl;
    logic [2:0]       r_flg;
    logic [2:0]       r_mode;
    logic             now, rise, expired;
    logic [2:0]       f_new;
    logic [31:0]      dl_new;
    logic             gen;
    res_t             gen_res;
    logic             can_push, push, step, take, last_push;
    logic             wr_rule, wr_add, wr_copy;
    res_t             status_res;
    logic             walk_end;

    assign idx     = pos_reg[IDX_W-1:0];
    assign pos_inc = pos_reg + 1'b1;
    assign idx_inc = pos_inc[IDX_W-1:0];
    assign r_ids   = ids_mem[idx];
    assign r_thr   = thr_mem[idx];
    assign r_ctl   = ctl_mem[idx];
    assign r_flg   = flg_mem[idx];
    assign r_dl    = dl_mem[idx];
    assign r_mode  = r_ctl[5:3];
    assign walk_end = (pos_reg >= cnt_reg);
    assign can_push = !out_valid_reg || !out_stall;

    // per-rule work for events and ticks
    always_comb
    begin
        now     = cmp_hit(r_ctl[2:0], req_reg.value, r_thr);
        rise    = now && !r_flg[0];
        expired = ((time_reg - r_dl) & 32'h8000_0000) == 32'd0;
        f_new   = r_flg;
        dl_new  = r_dl;
        gen     = 1'b0;
        gen_res.kind   = KIND_OUTPUT;
        gen_res.target = r_ids[31:16];
        gen_res.level  = 1'b0;
        gen_res.tog    = 1'b0;
        gen_res.pos    = 6'(pos_reg);
        gen_res.status = ST_OK;
        if (req_reg.cmd == CMD_EVENT)
        begin
            if (r_ids[15:0] == req_reg.src)
            begin
                f_new = {r_flg[2:1], now};
                case (r_mode)
                    MODE_FOLLOW:
                    begin
                        gen = 1'b1;
                        gen_res.level = now ? r_ctl[22] : r_ctl[23];
                        f_new = {2'b00, now};
                    end
                    MODE_PULSE:
                    begin
                        if (rise)
                        begin
                            gen = 1'b1;
                            gen_res.level = r_ctl[22];
                            f_new = {2'b11, now};
                            dl_new = time_reg + 32'(r_ctl[21:6]);
                        end
                    end
                    MODE_ON_DELAY:
                    begin
                        gen = 1'b1;
                        gen_res.level = r_ctl[23];
                        f_new[1] = now;
                        if (now)
                            dl_new = time_reg + 32'(r_ctl[21:6]);
                    end
                    MODE_OFF_DELAY:
                    begin
                        f_new[1] = !now;
                        if (now)
                        begin
                            gen = 1'b1;
                            gen_res.level = r_ctl[22];
                        end
                        else
                            dl_new = time_reg + 32'(r_ctl[21:6]);
                    end
                    MODE_TOGGLE:
                    begin
                        gen = rise;
                        gen_res.tog = 1'b1;
                    end
                    MODE_FORCE_ON:
                    begin
                        gen = rise;
                        gen_res.level = 1'b1;
                    end
                    MODE_FORCE_OFF:
                    begin
                        gen = rise;
                    end
                    default:
                    begin
                        gen = 1'b0;
                    end
                endcase
            end
        end
        else if (r_flg[1] && expired)
        begin
            f_new[1] = 1'b0;
            case (r_mode)
                MODE_PULSE:
                begin
                    if (r_flg[2])
                    begin
                        f_new[2] = 1'b0;
                        gen = 1'b1;
                        gen_res.level = r_ctl[23];
                    end
                end
                MODE_ON_DELAY:
                begin
                    gen = r_flg[0];
                    gen_res.level = r_ctl[22];
                end
                MODE_OFF_DELAY:
                begin
                    gen = !r_flg[0];
                    gen_res.level = r_ctl[23];
                end
                default:
                begin
                    gen = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        time_next       = time_reg;
        nres_next       = nres_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        push            = 1'b0;
        last_push       = 1'b0;
        take            = 1'b0;
        step            = 1'b0;
        wr_rule         = 1'b0;
        wr_add          = 1'b0;
        wr_copy         = 1'b0;
        status_res.kind   = KIND_STATUS;
        status_res.target = 16'd0;
        status_res.level  = 1'b0;
        status_res.tog    = 1'b0;
        status_res.pos    = 6'd0;
        status_res.status = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    pos_next  = '0;
                    nres_next = '0;
                    case (q_req.cmd)
                        CMD_EVENT:
                            state_next = S_WALK;
                        CMD_TICK:
                        begin
                            time_next  = time_reg + 32'd1;
                            state_next = S_WALK;
                        end
                        CMD_ADD:
                        begin
                            if (q_req.add_ok)
                                state_next = S_WALK;
                            else
                            begin
                                status_res.status = ST_INVALID;
                                take       = 1'b1;
                                state_next = S_FLUSH;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (7'(q_req.rm_idx) >= 7'(cnt_reg))
                            begin
                                status_res.status = ST_BAD_INDEX;
                                status_res.pos    = q_req.rm_idx;
                                take       = 1'b1;
                                state_next = S_FLUSH;
                            end
                            else
                            begin
                                pos_next   = CNT_W'(q_req.rm_idx);
                                state_next = S_SHIFT;
                            end
                        end
                        default:
                        begin
                            cnt_next   = '0;
                            take       = 1'b1;
                            state_next = S_FLUSH;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (req_reg.cmd == CMD_ADD)
                begin
                    if (walk_end)
                    begin
                        take       = 1'b1;
                        state_next = S_FLUSH;
                        if (cnt_reg >= CNT_W'(NUM_RULES))
                            status_res.status = ST_FULL;
                        else
                        begin
                            wr_add         = 1'b1;
                            status_res.pos = 6'(cnt_reg);
                            cnt_next       = cnt_reg + 1'b1;
                        end
                    end
                    else if ((r_ids == req_reg.ids) && (r_thr == req_reg.value) &&
                             (r_ctl == req_reg.ctl))
                    begin
                        status_res.status = ST_DUPLICATE;
                        take       = 1'b1;
                        state_next = S_FLUSH;
                    end
                    else if ((r_ids[31:16] == req_reg.ids[31:16]) &&
                             (!(is_force(r_mode) && is_force(req_reg.ctl[5:3])) ||
                              (r_mode == req_reg.ctl[5:3])))
                    begin
                        status_res.status = ST_CONFLICT;
                        take       = 1'b1;
                        state_next = S_FLUSH;
                    end
                    else
                        pos_next = pos_inc;
                end
                else if (walk_end)
                    state_next = S_FLUSH;
                else
                begin
                    // results past the cap are dropped but the rule still updates
                    if (gen && (nres_reg < RES_W'(MAX_RESULTS)))
                    begin
                        if (!pend_valid_reg || can_push)
                        begin
                            step = 1'b1;
                            push = pend_valid_reg;
                            pend_valid_next = 1'b1;
                            pend_next = gen_res;
                            nres_next = nres_reg + 1'b1;
                        end
                    end
                    else
                        step = 1'b1;
                    if (step)
                    begin
                        wr_rule  = 1'b1;
                        pos_next = pos_inc;
                    end
                end
            end
            S_SHIFT:
            begin
                if (pos_inc < cnt_reg)
                begin
                    wr_copy  = 1'b1;
                    pos_next = pos_inc;
                end
                else
                begin
                    cnt_next       = cnt_reg - 1'b1;
                    status_res.pos = req_reg.rm_idx;
                    take           = 1'b1;
                    state_next     = S_FLUSH;
                end
            end
            default:
            begin
                if (!pend_valid_reg)
                    state_next = S_IDLE;
                else if (can_push)
                begin
                    push       = 1'b1;
                    last_push  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
        endcase

        // status results land in an empty pending slot
        if (take)
        begin
            pend_valid_next = 1'b1;
            pend_next       = status_res;
        end

        if (push)
        begin
            out_valid_next = 1'b1;
            out_next       = pend_reg;
            out_last_next  = last_push;
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            time_reg       <= 32'd0;
            nres_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            time_reg       <= time_next;
            nres_reg       <= nres_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            req_reg <= q_req;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        if (wr_rule)
        begin
            flg_mem[idx] <= f_new;
            dl_mem[idx]  <= dl_new;
        end
        if (wr_add)
        begin
            ids_mem[cnt_reg[IDX_W-1:0]] <= req_reg.ids;
            thr_mem[cnt_reg[IDX_W-1:0]] <= req_reg.value;
            ctl_mem[cnt_reg[IDX_W-1:0]] <= req_reg.ctl;
            flg_mem[cnt_reg[IDX_W-1:0]] <= 3'b000;
            dl_mem[cnt_reg[IDX_W-1:0]]  <= 32'd0;
        end
        if (wr_copy)
        begin
            ids_mem[idx] <= ids_mem[idx_inc];
            thr_mem[idx] <= thr_mem[idx_inc];
            ctl_mem[idx] <= ctl_mem[idx_inc];
            flg_mem[idx] <= flg_mem[idx_inc];
            dl_mem[idx]  <= dl_mem[idx_inc];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: rtl/core/compare_rule_timer_engine.sv
// Flow: a request enters a two-entry queue; the back end pops it when idle, then walks the
// rules (events, ticks, add checks) or shifts the table down from the removed slot (remove),
// closes the walk and sends the final result from the flush state; the receiver can hold
// the walk and the flush by stalling.
// The back end takes one request at a time and pops the next only after the last is flushed.
// Reset: rule table empty, time count zero, both id limits 65535, queue and outputs empty.
module compare_rule_timer_engine
    import crte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [15:0] event_source,
    input  logic [31:0] event_value,
    input  logic [15:0] new_input_id,
    input  logic [15:0] new_output_id,
    input  logic [31:0] new_threshold,
    input  logic [2:0]  new_compare_op,
    input  logic [2:0]  new_mode,
    input  logic [15:0] new_duration,
    input  logic        new_level_true,
    input  logic        new_level_false,
    input  logic [5:0]  remove_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [15:0] target_output,
    output logic        level,
    output logic        toggle_request,
    output logic [5:0]  rule_position,
    output logic [2:0]  status,
    output logic        last
);

    logic q_valid;
    req_t q_req;
    logic q_pop;
    res_t res;

    crte_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .event_source    (event_source),
        .event_value     (event_value),
        .new_input_id    (new_input_id),
        .new_output_id   (new_output_id),
        .new_threshold   (new_threshold),
        .new_compare_op  (new_compare_op),
        .new_mode        (new_mode),
        .new_duration    (new_duration),
        .new_level_true  (new_level_true),
        .new_level_false (new_level_false),
        .remove_index    (remove_index),
        .q_valid         (q_valid),
        .q_req           (q_req),
        .q_pop           (q_pop)
    );

    crte_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_req     (q_req),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (res),
        .out_last  (last)
    );

    assign kind           = res.kind;
    assign target_output  = res.target;
    assign level          = res.level;
    assign toggle_request = res.tog;
    assign rule_position  = res.pos;
    assign status         = res.status;

endmodule
